[hdl/tpps_pkg.sv]
// Package for the timed pin pattern sequencer: function codes, the table entry
// layout, the result layout and default sizes.
// No dependencies.
`default_nettype none

package tpps_pkg;

    localparam int TABLE_SLOTS_DEF = 2048;
    localparam int INDEX_W         = 11;
    localparam int POS_W           = 12;
    localparam int REPEATS_W       = 16;
    localparam int NOW_W           = 48;
    localparam int END_W           = 49;
    localparam int DUR_W           = 23;
    localparam int VALUE_W         = 32;

    typedef enum logic [2:0] {
        FN_READ   = 3'd0,
        FN_WRITE  = 3'd1,
        FN_REMOVE = 3'd2,
        FN_START  = 3'd3,
        FN_STOP   = 3'd4,
        FN_STEP   = 3'd5
    } func_t;

    // One table word; a removed or never-written entry is all zero.
    typedef struct packed {
        logic               active;
        logic [3:0]         io;
        logic [3:0]         pin;
        logic [VALUE_W-1:0] value;
        logic [DUR_W-1:0]   duration;
    } entry_t;

    typedef struct packed {
        logic               status;
        logic               pin_write;
        logic               entry_active;
        logic [3:0]         io_port;
        logic [3:0]         pin_number;
        logic [VALUE_W-1:0] pin_value;
        logic [DUR_W-1:0]   step_duration;
        logic [END_W-1:0]   end_time_ms;
        logic               running;
        logic [POS_W-1:0]   position;
    } result_t;

endpackage

`default_nettype wire

[hdl/tpps_table.sv]
// Step table storage: single-port synchronous RAM with a registered read.
// Depends on tpps_pkg for the entry layout.
`default_nettype none

module tpps_table #(
    parameter int TABLE_SLOTS = tpps_pkg::TABLE_SLOTS_DEF
) (
    input  wire                             clk,
    input  wire                             we,
    input  wire  [$clog2(TABLE_SLOTS)-1:0]  addr,
    input  wire  tpps_pkg::entry_t          wdata,
    output tpps_pkg::entry_t                rdata
);
    import tpps_pkg::*;

    entry_t mem_reg [TABLE_SLOTS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/timed_pin_pattern_sequencer.sv]
// Timed pin pattern sequencer top level: request decode, playback state and
// result register. Depends on tpps_pkg and tpps_table.
//
// Usage:
//   Requests enter on in_valid/in_ready with func, index, io, pin, value,
//   duration, repeats and now_ms. Every request yields exactly one result on
//   out_valid/out_ready (status, pin_write, entry fields, end_time_ms,
//   running, position).
//   Write, remove, start, stop, unknown codes and out-of-range requests yield
//   a result from the accept itself; a read waits for its data (S_READ); a step
//   does so when stopped, else waits for the next entry (S_NEXT) and, on a wrap
//   to the start position, for the start entry (S_WRAP). The single table port
//   sets this: a step reads the next, then possibly the start entry, one per cycle.
//   One request is in flight at a time; a new request is taken in the cycle
//   its predecessor's result is taken or later.
//   Reset: playback is stopped (position -1) and a clearing pass writes every
//   table word to zero, one per cycle; in_ready stays low during the pass.
//   A stalled receiver holds the result in the output register; in_ready
//   drops until it is taken.
`default_nettype none

module timed_pin_pattern_sequencer #(
    parameter int TABLE_SLOTS = tpps_pkg::TABLE_SLOTS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,

    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [2:0]                    func,
    input  wire  [tpps_pkg::INDEX_W-1:0]  index,
    input  wire  [3:0]                    io,
    input  wire  [3:0]                    pin,
    input  wire  [tpps_pkg::VALUE_W-1:0]  value,
    input  wire  [tpps_pkg::DUR_W-1:0]    duration,
    input  wire  [tpps_pkg::REPEATS_W-1:0] repeats,
    input  wire  [tpps_pkg::NOW_W-1:0]    now_ms,

    output logic                          out_valid,
    input  wire                           out_ready,
    output logic                          status,
    output logic                          pin_write,
    output logic                          entry_active,
    output logic [3:0]                    io_port,
    output logic [3:0]                    pin_number,
    output logic [tpps_pkg::VALUE_W-1:0]  pin_value,
    output logic [tpps_pkg::DUR_W-1:0]    step_duration,
    output logic [tpps_pkg::END_W-1:0]    end_time_ms,
    output logic                          running,
    output logic signed [tpps_pkg::POS_W-1:0] position
);
    import tpps_pkg::*;

    localparam int AW = $clog2(TABLE_SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR,    // post-reset clearing pass
        S_IDLE,     // waiting for a request
        S_READ,     // read data of a read request arrives
        S_NEXT,     // step: next entry arrives
        S_WRAP      // step: start entry arrives after a wrap
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [INDEX_W-1:0]     start_reg, start_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [REPEATS_W-1:0]   rep_reg, rep_next;
    logic [END_W-1:0]       end_reg, end_next;
    logic                   next_ok_reg, next_ok_next;
    logic [NOW_W-1:0]       now_reg;
    logic                   out_valid_reg, out_valid_next;
    result_t                res_reg, res_next;

    // table port
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    entry_t                 mem_wdata;
    entry_t                 mem_rdata;

    logic                   accept;
    logic                   idx_ok;
    logic [POS_W-1:0]       pos_inc;
    logic                   pos_inc_ok;
    logic [REPEATS_W-1:0]   rep_dec;
    logic                   emit;
    entry_t                 emit_entry;

    tpps_table #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign in_ready   = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign idx_ok     = (32'(index) < 32'(TABLE_SLOTS));
    assign pos_inc    = pos_reg + POS_W'(1);
    // position past 2047 wraps negative, which also reads as "no entry"
    assign pos_inc_ok = !pos_inc[POS_W-1] && (32'(pos_inc) < 32'(TABLE_SLOTS));
    assign rep_dec    = rep_reg - REPEATS_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        start_next   = start_reg;
        pos_next     = pos_reg;
        rep_next     = rep_reg;
        end_next     = end_reg;
        next_ok_next = next_ok_reg;
        res_next     = res_reg;
        emit         = 1'b0;
        emit_entry   = '0;
        mem_we       = 1'b0;
        mem_addr     = AW'(index);
        mem_wdata    = '0;
        res_next.status    = res_reg.status;
        res_next.pin_write = res_reg.pin_write;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    emit               = 1'b1;
                    res_next.status    = 1'b0;
                    res_next.pin_write = 1'b0;
                    case (func_t'(func))
                        FN_READ:
                        begin
                            if (idx_ok)
                            begin
                                emit       = 1'b0;
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                        FN_WRITE:
                        begin
                            if (idx_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = '{active: 1'b1, io: io, pin: pin,
                                              value: value, duration: duration};
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                        FN_REMOVE:
                        begin
                            if (idx_ok)
                            begin
                                mem_we = 1'b1;
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                        FN_START:
                        begin
                            if (idx_ok)
                            begin
                                start_next = index;
                                pos_next   = POS_W'(index) - POS_W'(1);
                                end_next   = '0;
                                rep_next   = repeats;
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                        FN_STOP:
                        begin
                            start_next = '0;
                            pos_next   = '1;
                            end_next   = '0;
                            rep_next   = '0;
                        end
                        FN_STEP:
                        begin
                            // stopped: nothing changes
                            if (rep_reg != '0)
                            begin
                                emit         = 1'b0;
                                pos_next     = pos_inc;
                                next_ok_next = pos_inc_ok;
                                mem_addr     = AW'(pos_inc[INDEX_W-1:0]);
                                state_next   = S_NEXT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_READ:
            begin
                emit       = 1'b1;
                emit_entry = mem_rdata;
                state_next = S_IDLE;
            end

            S_NEXT:
            begin
                if (next_ok_reg && mem_rdata.active)
                begin
                    emit               = 1'b1;
                    emit_entry         = mem_rdata;
                    res_next.pin_write = 1'b1;
                    end_next           = END_W'(now_reg) + END_W'(mem_rdata.duration);
                    state_next         = S_IDLE;
                end
                else if (rep_dec == '0)
                begin
                    // last pass used up
                    emit       = 1'b1;
                    rep_next   = '0;
                    start_next = '0;
                    pos_next   = '1;
                    end_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    rep_next   = rep_dec;
                    pos_next   = POS_W'(start_reg);
                    mem_addr   = AW'(start_reg);
                    state_next = S_WRAP;
                end
            end

            S_WRAP:
            begin
                emit       = 1'b1;
                state_next = S_IDLE;
                if (mem_rdata.active)
                begin
                    emit_entry         = mem_rdata;
                    res_next.pin_write = 1'b1;
                    end_next           = END_W'(now_reg) + END_W'(mem_rdata.duration);
                end
                else
                begin
                    rep_next   = '0;
                    start_next = '0;
                    pos_next   = '1;
                    end_next   = '0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            res_next.entry_active  = emit_entry.active;
            res_next.io_port       = emit_entry.io;
            res_next.pin_number    = emit_entry.pin;
            res_next.pin_value     = emit_entry.value;
            res_next.step_duration = emit_entry.duration;
            res_next.end_time_ms   = end_next;
            res_next.running       = (rep_next != '0);
            res_next.position      = pos_next;
        end

        out_valid_next = (out_valid_reg && !out_ready) || emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            start_reg     <= '0;
            pos_reg       <= '1;
            rep_reg       <= '0;
            end_reg       <= '0;
            next_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            start_reg     <= start_next;
            pos_reg       <= pos_next;
            rep_reg       <= rep_next;
            end_reg       <= end_next;
            next_ok_reg   <= next_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            now_reg <= now_ms;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign pin_write     = res_reg.pin_write;
    assign entry_active  = res_reg.entry_active;
    assign io_port       = res_reg.io_port;
    assign pin_number    = res_reg.pin_number;
    assign pin_value     = res_reg.pin_value;
    assign step_duration = res_reg.step_duration;
    assign end_time_ms   = res_reg.end_time_ms;
    assign running       = res_reg.running;
    assign position      = res_reg.position;

endmodule

`default_nettype wire
